[rtl/psll_pkg.sv]
// Package for the pooled singly linked list: sizes, codes, memory port structs.
// Used by the interfaces, the sequencer and the top level.
package psll_pkg;

    localparam int POOL_NODES = 1024;
    localparam int DEPTH      = POOL_NODES + 1;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int ALLOC_W    = $clog2(POOL_NODES + 2);
    localparam int MODE_W     = 3;
    localparam int POS_W      = 11;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [ALLOC_W-1:0] t_alloc;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [DATA_W-1:0]  t_data;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FIRST = 3'd0,
        MODE_INS_AT    = 3'd1,
        MODE_INS_LAST  = 3'd2,
        MODE_DEL_FIRST = 3'd3,
        MODE_DEL_AT    = 3'd4,
        MODE_DEL_LAST  = 3'd5,
        MODE_READ      = 3'd6
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BEYOND = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Link memory port: one write and one read address per cycle.
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_idx wdata;
        t_idx raddr;
    } t_link_port;

    // Value memory port.
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_data wdata;
        t_idx  raddr;
    } t_val_port;

endpackage

[rtl/psll_in_if.sv]
// Request channel of the pooled singly linked list: valid/ready plus payload.
// Depends on psll_pkg for field widths.
interface psll_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [psll_pkg::MODE_W-1:0]             mode;
    logic [psll_pkg::POS_W-1:0]              position;
    logic signed [psll_pkg::DATA_W-1:0]      value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

[rtl/psll_out_if.sv]
// Result channel of the pooled singly linked list: valid/ready plus payload.
// Depends on psll_pkg for field widths.
interface psll_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [psll_pkg::STATUS_W-1:0]           status;
    logic signed [psll_pkg::DATA_W-1:0]      read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

[rtl/psll_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module psll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/psll_ctrl.sv]
// Sequencer of the pooled singly linked list: link walk, node updates, result register.
// Depends on psll_pkg, psll_in_if and psll_out_if; drives the two node memories.
module psll_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    psll_in_if.sink              i_req,
    psll_out_if.source           o_rsp,
    output psll_pkg::t_link_port o_link,
    input  psll_pkg::t_idx       i_link_q,
    output psll_pkg::t_val_port  o_val,
    input  psll_pkg::t_data      i_val_q
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINK,
        S_DEL,
        S_RDV,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [psll_pkg::MODE_W-1:0]  r_mode;
    psll_pkg::t_pos               r_rem;
    psll_pkg::t_idx               r_cur;
    psll_pkg::t_idx               r_prev;
    psll_pkg::t_idx               r_nd;
    psll_pkg::t_idx               r_head;
    psll_pkg::t_alloc             r_alloc;
    psll_pkg::t_data              r_value;
    psll_pkg::t_status            r_status;
    psll_pkg::t_data              r_rd;
    logic                         r_out_valid;
    psll_pkg::t_status            r_out_status;
    psll_pkg::t_data              r_out_rd;

    psll_pkg::t_idx               w_nx;
    psll_pkg::t_idx               w_new;
    logic                         w_full;
    logic                         w_to_end;
    logic                         w_walk_end;
    logic                         w_slot_free;

    // Successor of the current node: head register for the sentinel, memory otherwise.
    assign w_nx        = (r_cur == '0) ? r_head : i_link_q;
    assign w_new       = r_alloc[psll_pkg::IDX_W-1:0];
    assign w_full      = r_alloc > psll_pkg::t_alloc'(psll_pkg::POOL_NODES);
    assign w_to_end    = (r_mode == psll_pkg::MODE_INS_LAST) ||
                         (r_mode == psll_pkg::MODE_DEL_LAST);
    assign w_walk_end  = w_to_end ? (w_nx == '0) : (r_rem == '0);
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_rd;

    // Memory ports; read addresses always follow the successor so the walk
    // issues the next read in the cycle it learns the next node.
    always_comb begin
        o_link       = '0;
        o_val        = '0;
        o_link.raddr = w_nx;
        o_val.raddr  = w_nx;
        case (r_state)
            S_WALK: begin
                if (w_walk_end) begin
                    case (r_mode) inside
                        psll_pkg::MODE_INS_FIRST, psll_pkg::MODE_INS_AT,
                        psll_pkg::MODE_INS_LAST: begin
                            if (!w_full) begin
                                o_val.we     = 1'b1;
                                o_val.waddr  = w_new;
                                o_val.wdata  = r_value;
                                o_link.we    = 1'b1;
                                o_link.waddr = w_new;
                                o_link.wdata = w_nx;
                            end
                        end
                        psll_pkg::MODE_DEL_LAST: begin
                            if (r_prev != '0) begin
                                o_link.we    = 1'b1;
                                o_link.waddr = r_prev;
                                o_link.wdata = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LINK: begin
                o_link.we    = 1'b1;
                o_link.waddr = r_cur;
                o_link.wdata = r_nd;
            end
            S_DEL: begin
                if (r_cur != '0) begin
                    o_link.we    = 1'b1;
                    o_link.waddr = r_cur;
                    o_link.wdata = i_link_q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_alloc     <= psll_pkg::t_alloc'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode  <= i_req.mode;
                        r_value <= i_req.value;
                        r_cur   <= '0;
                        r_prev  <= '0;
                        r_rd    <= '0;
                        if (((i_req.mode == psll_pkg::MODE_INS_AT) ||
                             (i_req.mode == psll_pkg::MODE_DEL_AT) ||
                             (i_req.mode == psll_pkg::MODE_READ)) &&
                            (i_req.position > psll_pkg::t_pos'(1))) begin
                            r_rem <= i_req.position - 1'b1;
                        end else begin
                            r_rem <= '0;
                        end
                        unique case (i_req.mode) inside
                            psll_pkg::MODE_INS_FIRST, psll_pkg::MODE_INS_AT,
                            psll_pkg::MODE_INS_LAST: begin
                                r_state <= S_WALK;
                            end
                            psll_pkg::MODE_DEL_FIRST, psll_pkg::MODE_DEL_AT,
                            psll_pkg::MODE_DEL_LAST, psll_pkg::MODE_READ: begin
                                if (r_head == '0) begin
                                    r_status <= psll_pkg::ST_EMPTY;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state  <= S_WALK;
                                end
                            end
                            default: begin
                                r_status <= psll_pkg::ST_DONE;
                                r_state  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (w_walk_end) begin
                        unique case (r_mode) inside
                            psll_pkg::MODE_INS_FIRST, psll_pkg::MODE_INS_AT,
                            psll_pkg::MODE_INS_LAST: begin
                                if (w_full) begin
                                    r_status <= psll_pkg::ST_FULL;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_alloc <= r_alloc + 1'b1;
                                    if (r_cur == '0) begin
                                        r_head   <= w_new;
                                        r_status <= psll_pkg::ST_DONE;
                                        r_state  <= S_EMIT;
                                    end else begin
                                        r_nd    <= w_new;
                                        r_state <= S_LINK;
                                    end
                                end
                            end
                            psll_pkg::MODE_DEL_FIRST, psll_pkg::MODE_DEL_AT: begin
                                if (w_nx == '0) begin
                                    r_status <= psll_pkg::ST_BEYOND;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_nd    <= w_nx;
                                    r_state <= S_DEL;
                                end
                            end
                            psll_pkg::MODE_DEL_LAST: begin
                                if (r_prev == '0) begin
                                    r_head <= '0;
                                end
                                r_status <= psll_pkg::ST_DONE;
                                r_state  <= S_EMIT;
                            end
                            psll_pkg::MODE_READ: begin
                                if (w_nx == '0) begin
                                    r_status <= psll_pkg::ST_BEYOND;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_RDV;
                                end
                            end
                            default: begin
                                r_status <= psll_pkg::ST_DONE;
                                r_state  <= S_EMIT;
                            end
                        endcase
                    end else if (w_nx == '0) begin
                        // ran off the list before reaching the position
                        r_status <= psll_pkg::ST_BEYOND;
                        r_state  <= S_EMIT;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= w_nx;
                        r_rem  <= r_rem - 1'b1;
                    end
                end
                S_LINK: begin
                    r_status <= psll_pkg::ST_DONE;
                    r_state  <= S_EMIT;
                end
                S_DEL: begin
                    if (r_cur == '0) begin
                        r_head <= i_link_q;
                    end
                    r_status <= psll_pkg::ST_DONE;
                    r_state  <= S_EMIT;
                end
                S_RDV: begin
                    r_rd     <= i_val_q;
                    r_status <= psll_pkg::ST_DONE;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_rd     <= r_rd;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_alloc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alloc >= psll_pkg::t_alloc'(1)) &&
        (r_alloc <= psll_pkg::t_alloc'(psll_pkg::POOL_NODES + 1)))
        else $error("allocation count out of range");

    a_walk_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cur != '0) |-> (psll_pkg::t_alloc'(r_cur) < r_alloc))
        else $error("walk reached a node that was never allocated");

    a_head_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != '0) |-> (psll_pkg::t_alloc'(r_head) < r_alloc))
        else $error("head points at an unallocated node");

    a_link_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_link.we |-> (psll_pkg::t_alloc'(o_link.waddr) <= r_alloc) &&
                      (o_link.waddr != '0))
        else $error("link write outside the allocated nodes");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_slot_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished request did not reach the result register");
`endif

endmodule

[rtl/pooled_singly_linked_list.sv]
// Pooled singly linked list of signed 32-bit words: top level.
// Depends on psll_pkg, psll_in_if, psll_out_if, psll_ram and psll_ctrl.
//
// One request carries a mode (insert first / at position / last, delete
// first / at position / last, read at position), a one-based position and a
// data word; every request returns exactly one result with a status (done,
// position beyond the list, pool exhausted, list empty) and, for a
// successful read, the data word found. Nodes come from a bump allocator and
// are never reclaimed, so at most POOL_NODES inserts ever succeed. Requests
// are handled one at a time, and the link walk sets the time of each one:
// it follows one link per cycle through the link memory, whose registered
// read paces the whole operation. The block is back in idle when the result
// is loaded. The result sits in an output register, so the next request is
// accepted while the previous result still waits to be taken. The head
// pointer and the allocation count are flip-flops; reset clears the head
// and sets the count to one. The node memories need no clearing pass,
// since only nodes written by an insert are ever reached.
module pooled_singly_linked_list (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psll_in_if.sink    i_req,
    psll_out_if.source o_rsp
);

    psll_pkg::t_link_port w_link;
    psll_pkg::t_val_port  w_val;
    psll_pkg::t_idx       w_link_q;
    psll_pkg::t_data      w_val_q;

    // Sequencer: walks the list, updates links, holds the result register.
    psll_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .o_link   (w_link),
        .i_link_q (w_link_q),
        .o_val    (w_val),
        .i_val_q  (w_val_q)
    );

    // Successor index of each node; entry 0 stays unused, the head is a register.
    psll_ram #(
        .WIDTH (psll_pkg::IDX_W),
        .DEPTH (psll_pkg::DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link.we),
        .i_waddr (w_link.waddr),
        .i_wdata (w_link.wdata),
        .i_raddr (w_link.raddr),
        .o_rdata (w_link_q)
    );

    // Data word of each node, written once when the node is taken.
    psll_ram #(
        .WIDTH (psll_pkg::DATA_W),
        .DEPTH (psll_pkg::DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val.we),
        .i_waddr (w_val.waddr),
        .i_wdata (w_val.wdata),
        .i_raddr (w_val.raddr),
        .o_rdata (w_val_q)
    );

endmodule
